@@ rtl/rbs_pkg.sv @@
// Shared types and constants for the ray/box slab intersection block.
// Used by every module under rtl; depends on nothing else.
package rbs_pkg;

  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int LW       = 31;
  localparam int NAX      = 3;
  localparam int NREG     = 6;
  localparam int DW       = 32;
  localparam int AW       = $clog2(NREG * 4);
  localparam int RIW      = $clog2(NREG);
  localparam int QB       = CW - 1;
  localparam int SH       = CW - 1 - FB;
  localparam int DIV_LAT  = QB + 3;
  localparam int LANE_LAT = DIV_LAT + 2;

  localparam logic [RIW-1:0] REG_BOX_LO_X = RIW'(0);
  localparam logic [RIW-1:0] REG_BOX_LO_Y = RIW'(1);
  localparam logic [RIW-1:0] REG_BOX_LO_Z = RIW'(2);
  localparam logic [RIW-1:0] REG_BOX_HI_X = RIW'(3);
  localparam logic [RIW-1:0] REG_BOX_HI_Y = RIW'(4);
  localparam logic [RIW-1:0] REG_BOX_HI_Z = RIW'(5);

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t T_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t          org_x;
    coord_t          org_y;
    coord_t          org_z;
    coord_t          dir_x;
    coord_t          dir_y;
    coord_t          dir_z;
    logic [LW-1:0]   ray_limit;
  } in_word_t;

  typedef struct packed {
    logic   hit;
    coord_t near_t;
    coord_t far_t;
  } out_word_t;

  typedef struct packed {
    logic   par_miss;
    logic   dir_zero;
    coord_t near_t;
    coord_t far_t;
  } lane_res_t;

endpackage

@@ rtl/rbs_div.sv @@
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
// Depends on rbs_pkg.
module rbs_div import rbs_pkg::*; (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic signed [CW:0] num_i,
  input  coord_t          den_i,
  output coord_t          quo_o
);

  localparam int OW = CW + 1 + SH;

  logic [CW:0]   a0_q;
  logic [CW-1:0] d0_q;
  logic          neg0_q;

  logic [CW:0]   a_q   [0:QB];
  logic [CW-1:0] d_q   [0:QB];
  logic          neg_q [0:QB];
  logic          ovf_q [0:QB];
  logic [CW-1:0] rem_q [0:QB];
  logic [QB-1:0] q_q   [0:QB];

  coord_t        quo_q;

  logic [CW:0]   a_d;
  logic [CW-1:0] d_d;
  logic [OW-1:0] cmp_a, cmp_d;

  always_comb begin
    a_d   = num_i[CW] ? (CW+1)'(-num_i) : num_i;
    d_d   = den_i[CW-1] ? CW'(-den_i) : den_i;
    cmp_a = OW'(a0_q);
    cmp_d = OW'({d0_q, {SH{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a0_q     <= a_d;
      d0_q     <= d_d;
      neg0_q   <= num_i[CW] ^ den_i[CW-1];
      a_q[0]   <= a0_q;
      d_q[0]   <= d0_q;
      neg_q[0] <= neg0_q;
      ovf_q[0] <= cmp_a >= cmp_d;
      rem_q[0] <= CW'(a0_q >> SH);
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int J = QB - 1 - k;
    logic          nbit;
    logic [CW:0]   sh;
    logic [CW:0]   dx;
    logic          ge;
    if (J >= FB) begin : g_dat
      assign nbit = a_q[k][J-FB];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign sh = {rem_q[k], nbit};
    assign dx = {1'b0, d_q[k]};
    assign ge = sh >= dx;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q[k+1]   <= a_q[k];
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
        rem_q[k+1] <= ge ? CW'(sh - dx) : CW'(sh);
        q_q[k+1]   <= {q_q[k][QB-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (ovf_q[QB]) begin
        quo_q <= neg_q[QB] ? T_MIN : T_MAX;
      end else if (neg_q[QB]) begin
        quo_q <= -coord_t'({1'b0, q_q[QB]});
      end else begin
        quo_q <= coord_t'({1'b0, q_q[QB]});
      end
    end
  end

  assign quo_o = quo_q;

endmodule

@@ rtl/rbs_lane.sv @@
// One axis lane: slab offsets, two dividers, parallel test and ordering.
// Depends on rbs_pkg and rbs_div.
module rbs_lane import rbs_pkg::*; (
  input  logic      clk_i,
  input  logic      adv_i,
  input  coord_t    org_i,
  input  coord_t    dir_i,
  input  coord_t    lo_i,
  input  coord_t    hi_i,
  output lane_res_t res_o
);

  logic signed [CW:0] dlo_q, dhi_q;
  coord_t             dir_q;
  logic               dz_q, pm_q;
  logic               dz_l_q [0:DIV_LAT-1];
  logic               pm_l_q [0:DIV_LAT-1];
  coord_t             x, y;
  lane_res_t          res_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dlo_q <= {lo_i[CW-1], lo_i} - {org_i[CW-1], org_i};
      dhi_q <= {hi_i[CW-1], hi_i} - {org_i[CW-1], org_i};
      dir_q <= dir_i;
      dz_q  <= dir_i == '0;
      pm_q  <= (dir_i == '0) && ((org_i < lo_i) || (org_i > hi_i));
      dz_l_q[0] <= dz_q;
      pm_l_q[0] <= pm_q;
    end
  end

  for (genvar i = 1; i < DIV_LAT; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dz_l_q[i] <= dz_l_q[i-1];
        pm_l_q[i] <= pm_l_q[i-1];
      end
    end
  end

  rbs_div u_div_lo (.clk_i, .adv_i, .num_i(dlo_q), .den_i(dir_q), .quo_o(x));
  rbs_div u_div_hi (.clk_i, .adv_i, .num_i(dhi_q), .den_i(dir_q), .quo_o(y));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q.par_miss <= pm_l_q[DIV_LAT-1];
      res_q.dir_zero <= dz_l_q[DIV_LAT-1];
      if (dz_l_q[DIV_LAT-1]) begin
        res_q.near_t <= '0;
        res_q.far_t  <= T_MAX;
      end else if (x > y) begin
        res_q.near_t <= y;
        res_q.far_t  <= x;
      end else begin
        res_q.near_t <= x;
        res_q.far_t  <= y;
      end
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/rbs_merge.sv @@
// Merge of the three lane intervals into the clipped ray interval, three stages.
// Depends on rbs_pkg.
module rbs_merge import rbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [LW-1:0]   limit_i,
  input  lane_res_t [NAX-1:0] lane_i,
  output logic            valid_o,
  output out_word_t       word_o
);

  logic      v1_q, v2_q, v3_q;
  coord_t    n01_q, n2_q, f01_q, f2_q, near_q, far_q;
  logic      pm1_q, pm2_q;
  logic      az1_q, az2_q;
  out_word_t word_q;
  coord_t    lim;

  assign lim = coord_t'(CW'(limit_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // an all-parallel ray is never tested for an empty interval
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      n01_q  <= (lane_i[0].near_t > lane_i[1].near_t) ? lane_i[0].near_t : lane_i[1].near_t;
      n2_q   <= (lane_i[2].near_t > coord_t'(0)) ? lane_i[2].near_t : coord_t'(0);
      f01_q  <= (lane_i[0].far_t < lane_i[1].far_t) ? lane_i[0].far_t : lane_i[1].far_t;
      f2_q   <= (lane_i[2].far_t < lim) ? lane_i[2].far_t : lim;
      pm1_q  <= lane_i[0].par_miss | lane_i[1].par_miss | lane_i[2].par_miss;
      az1_q  <= lane_i[0].dir_zero & lane_i[1].dir_zero & lane_i[2].dir_zero;
      near_q <= (n01_q > n2_q) ? n01_q : n2_q;
      far_q  <= (f01_q < f2_q) ? f01_q : f2_q;
      pm2_q  <= pm1_q;
      az2_q  <= az1_q;
      if (!pm2_q && (az2_q || (far_q > near_q))) begin
        word_q <= '{hit: 1'b1, near_t: near_q, far_t: far_q};
      end else begin
        word_q <= '0;
      end
    end
  end

  assign valid_o = v3_q;
  assign word_o  = word_q;

endmodule

@@ rtl/ray_box_slab_intersection_top.sv @@
// Top level of the ray/box slab intersection block: box registers, lanes, output buffer.
// Depends on rbs_pkg, rbs_lane, rbs_merge.
//
// Usage: the box corners sit in six APB registers (lo x/y/z at 0x00..0x08,
// hi x/y/z at 0x0C..0x14), all reset to 0; write them while no ray is in flight.
// Rays enter as one word on in_valid_i/in_ready_o; each ray gives exactly one
// result word (hit, near_t, far_t) on out_valid_o/out_ready_i, in order.
// Throughput is one ray per cycle while in_ready_o is high. Each ray passes through
// the divider pipelines: one quotient bit per stage, two dividers per axis lane,
// three lanes side by side. When the receiver stalls, an output register and a
// skid register absorb the word in motion; the pipeline then freezes and in_ready_o
// is low while the skid register holds a word, so no word is lost. Reset
// empties every stage and clears the box.
module ray_box_slab_intersection_top import rbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [AW-1:0]   paddr,
  input  logic [DW-1:0]   pwdata,
  output logic [DW-1:0]   prdata,
  output logic            pready
);

  coord_t          lo_q [NAX];
  coord_t          hi_q [NAX];
  logic [RIW-1:0]  ridx;
  logic            adv;

  in_word_t        in_q;
  logic            v0_q;
  logic            vl_q  [0:LANE_LAT-1];
  logic [LW-1:0]   lim_q [0:LANE_LAT-1];
  lane_res_t [NAX-1:0] lane_res;
  coord_t          org [NAX];
  coord_t          dir [NAX];

  logic            pv;
  out_word_t       pw;
  logic            out_valid_q, skid_valid_q;
  out_word_t       out_q, skid_q;

  assign pready = 1'b1;
  assign ridx   = paddr[AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_BOX_LO_X: lo_q[0] <= coord_t'(pwdata);
        REG_BOX_LO_Y: lo_q[1] <= coord_t'(pwdata);
        REG_BOX_LO_Z: lo_q[2] <= coord_t'(pwdata);
        REG_BOX_HI_X: hi_q[0] <= coord_t'(pwdata);
        REG_BOX_HI_Y: hi_q[1] <= coord_t'(pwdata);
        REG_BOX_HI_Z: hi_q[2] <= coord_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_BOX_LO_X: prdata = DW'(lo_q[0]);
      REG_BOX_LO_Y: prdata = DW'(lo_q[1]);
      REG_BOX_LO_Z: prdata = DW'(lo_q[2]);
      REG_BOX_HI_X: prdata = DW'(hi_q[0]);
      REG_BOX_HI_Y: prdata = DW'(hi_q[1]);
      REG_BOX_HI_Z: prdata = DW'(hi_q[2]);
      default:      prdata = '0;
    endcase
  end

  assign adv        = !skid_valid_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = 0; i < LANE_LAT; i++) vl_q[i] <= 1'b0;
    end else if (adv) begin
      v0_q    <= in_valid_i;
      vl_q[0] <= v0_q;
      for (int i = 1; i < LANE_LAT; i++) vl_q[i] <= vl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q     <= in_word_i;
      lim_q[0] <= in_q.ray_limit;
      for (int i = 1; i < LANE_LAT; i++) lim_q[i] <= lim_q[i-1];
    end
  end

  assign org[0] = in_q.org_x;
  assign org[1] = in_q.org_y;
  assign org[2] = in_q.org_z;
  assign dir[0] = in_q.dir_x;
  assign dir[1] = in_q.dir_y;
  assign dir[2] = in_q.dir_z;

  for (genvar a = 0; a < NAX; a++) begin : g_lane
    rbs_lane u_lane (
      .clk_i,
      .adv_i (adv),
      .org_i (org[a]),
      .dir_i (dir[a]),
      .lo_i  (lo_q[a]),
      .hi_i  (hi_q[a]),
      .res_o (lane_res[a])
    );
  end

  rbs_merge u_merge (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .valid_i (vl_q[LANE_LAT-1]),
    .limit_i (lim_q[LANE_LAT-1]),
    .lane_i  (lane_res),
    .valid_o (pv),
    .word_o  (pw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || pv;
      skid_valid_q <= 1'b0;
    end else if (pv && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : pw;
    end else if (pv && adv) begin
      skid_q <= pw;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.hit) |-> (out_word_o.near_t == '0 && out_word_o.far_t == '0))
    else $error("miss word carries nonzero distances");

  a_hit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.hit) |-> (out_word_o.far_t >= out_word_o.near_t))
    else $error("hit word with reversed interval");

  a_hit_near_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.hit) |-> (out_word_o.near_t >= coord_t'(0)))
    else $error("hit word with negative entry distance");
`endif

endmodule
